[rtl/core/bayer_row_pair_vertical_upscaler_top_assert.svh]
// Assertion macros for the upscaler's top level.
`ifndef BAYER_ROW_PAIR_VERTICAL_UPSCALER_TOP_ASSERT_SVH
`define BAYER_ROW_PAIR_VERTICAL_UPSCALER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define BRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brp assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define BRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brp assertion failed");

`endif

[rtl/core/brp_pkg.sv]
package brp_pkg;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Register reset values and the width that turns on the downward shift.
    localparam logic [9:0] FRAME_WIDTH_RST  = 10'd640;
    localparam logic [8:0] FRAME_HEIGHT_RST = 9'd480;
    localparam logic [9:0] SHIFT_WIDTH      = 10'd176;

    // Result kinds of one input word, in emission order.
    localparam logic [1:0] KIND_COPY = 2'd0;
    localparam logic [1:0] KIND_AVG  = 2'd1;
    localparam logic [1:0] KIND_DUP  = 2'd2;

    // Effective frame settings after clamping.
    typedef struct packed {
        logic [9:0] width;
        logic [8:0] height;
        logic       shift;
    } cfg_t;

    // Payload of one item on its way to the result stage.
    typedef struct packed {
        logic [9:0] base;
        logic [9:0] col;
        logic [7:0] pixel;
        logic [7:0] avg;
        logic       shift;
    } pix_t;

    // Item handed from the store stage to the result stage. Mask bit 2k is
    // the in-place copy and bit 2k+1 the main copy of result kind k.
    typedef struct packed {
        logic       valid;
        logic [5:0] mask;
        pix_t       data;
    } item_t;

endpackage

[rtl/core/brp_ram.sv]
module brp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1280
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read and a write to the same entry return the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/brp_front.sv]
module brp_front #(
    parameter int MAX_WIDTH  = 640,
    parameter int SHIFT_ROWS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  brp_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    pixel,
    input  logic          take,
    output brp_pkg::item_t item
);

    localparam int DEPTH = 2 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]    row_cnt_reg, row_cnt_next;
    logic [9:0]    col_cnt_reg, col_cnt_next;
    logic          a_valid_reg, a_valid_next;
    logic [9:0]    a_base_reg;
    logic [9:0]    a_col_reg;
    logic [7:0]    a_pixel_reg;
    logic          a_avg_en_reg;
    logic          a_dup_en_reg;

    logic          acc;
    logic          a_adv;
    logic [9:0]    j;
    logic [7:0]    half;
    logic [AW-1:0] idx;
    logic [9:0]    base;
    logic          avg_en;
    logic          dup_en;
    logic          last_col;
    logic          row_wrap;
    logic [7:0]    rdata;
    logic [8:0]    sum;
    logic [9:0]    rows [3];
    logic [2:0]    kind_en;
    logic [5:0]    mask;

    assign a_adv    = a_valid_reg & take;
    assign in_ready = ~a_valid_reg | take;
    assign acc      = in_valid & in_ready;

    // Position of this word in the frame, with the column clamped to the row.
    always_comb
    begin
        half     = cfg.height[8:1];
        j        = (col_cnt_reg >= cfg.width) ? (cfg.width - 10'd1) : col_cnt_reg;
        idx      = row_cnt_reg[0] ? (AW'(MAX_WIDTH) + AW'(j)) : AW'(j);
        base     = {1'b0, row_cnt_reg, 1'b0} - {9'd0, row_cnt_reg[0]};
        avg_en   = row_cnt_reg >= 8'd2;
        dup_en   = ({1'b0, row_cnt_reg} + 9'd2) >= {1'b0, half};
        last_col = ({1'b0, j} + 11'd1) >= {1'b0, cfg.width};
        row_wrap = ({1'b0, row_cnt_reg} + 9'd1) >= {1'b0, half};
    end

    // Column and row counters advance on every accepted word.
    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (acc)
        begin
            if (last_col)
            begin
                col_cnt_next = 10'd0;
                row_cnt_next = row_wrap ? 8'd0 : (row_cnt_reg + 8'd1);
            end
            else
            begin
                col_cnt_next = j + 10'd1;
            end
        end
    end

    // Stage A holds one word, with its store read, until the result stage takes it.
    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (acc)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= 8'd0;
            col_cnt_reg <= 10'd0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            a_base_reg   <= base;
            a_col_reg    <= j;
            a_pixel_reg  <= pixel;
            a_avg_en_reg <= avg_en;
            a_dup_en_reg <= dup_en;
        end
    end

    // Row pair store: read the same-parity byte and write the new one at once.
    brp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (acc),
        .waddr (idx),
        .wdata (pixel),
        .re    (acc),
        .raddr (idx),
        .rdata (rdata)
    );

    // Result rows and which of them land inside the frame.
    always_comb
    begin
        rows[0]    = a_base_reg;
        rows[1]    = a_base_reg - 10'd2;
        rows[2]    = a_base_reg + 10'd2;
        kind_en[0] = 1'b1;
        kind_en[1] = a_avg_en_reg;
        kind_en[2] = a_dup_en_reg;
        for (int k = 0; k < 3; k++)
        begin
            mask[2*k]   = kind_en[k] & cfg.shift & (rows[k] < 10'(SHIFT_ROWS))
                          & (rows[k] < {1'b0, cfg.height});
            mask[2*k+1] = kind_en[k] & (cfg.shift
                          ? ((rows[k] + 10'(SHIFT_ROWS)) < {1'b0, cfg.height})
                          : (rows[k] < {1'b0, cfg.height}));
        end
    end

    assign sum = {1'b0, rdata} + {1'b0, a_pixel_reg};

    always_comb
    begin
        item.valid      = a_valid_reg;
        item.mask       = mask;
        item.data.base  = a_base_reg;
        item.data.col   = a_col_reg;
        item.data.pixel = a_pixel_reg;
        item.data.avg   = sum[8:1];
        item.data.shift = cfg.shift;
    end

endmodule

[rtl/core/brp_emit.sv]
module brp_emit #(
    parameter int SHIFT_ROWS = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  brp_pkg::item_t item,
    output logic           take,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [8:0]     out_row,
    output logic [9:0]     out_col,
    output logic [7:0]     value,
    output logic           last_of_run
);

    logic [5:0]     mask_reg, mask_next;
    brp_pkg::pix_t  data_reg;

    logic           load;
    logic           fire;
    logic [2:0]     slot;
    logic [1:0]     kind;
    logic [9:0]     row_k;
    logic [9:0]     row_out;
    logic [5:0]     mask_rest;

    assign out_valid   = |mask_reg;
    assign mask_rest   = mask_reg & (mask_reg - 6'd1);
    assign last_of_run = mask_rest == 6'd0;
    assign fire        = out_valid & out_ready;
    assign take        = ~out_valid | (out_ready & last_of_run);
    assign load        = item.valid & take & (|item.mask);

    // Lowest pending result goes out first.
    always_comb
    begin
        slot = 3'd0;
        for (int i = 5; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                slot = 3'(i);
            end
        end
    end

    assign kind = slot[2:1];

    always_comb
    begin
        unique case (kind)
            brp_pkg::KIND_COPY: row_k = data_reg.base;
            brp_pkg::KIND_AVG:  row_k = data_reg.base - 10'd2;
            brp_pkg::KIND_DUP:  row_k = data_reg.base + 10'd2;
            default:            row_k = data_reg.base;
        endcase
        row_out = (slot[0] & data_reg.shift) ? (row_k + 10'(SHIFT_ROWS)) : row_k;
    end

    assign out_row = row_out[8:0];
    assign out_col = data_reg.col;
    assign value   = (kind == brp_pkg::KIND_AVG) ? data_reg.avg : data_reg.pixel;

    // Pending mask: load a new word or retire the result just taken.
    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = item.mask;
        end
        else if (fire)
        begin
            mask_next = mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 6'd0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= item.data;
        end
    end

endmodule

[rtl/core/bayer_row_pair_vertical_upscaler_top.sv]
// Channel  Handshake             Word
// in       in_valid / in_ready   pixel
// out      out_valid / out_ready out_row, out_col, value, last_of_run
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An accepted word is held in stage A until the result register takes it.
// It then gives up to six results (two for most words), one word per cycle
// while out_ready is high; the next word is accepted meanwhile.
// Reset clears the row and column counters and loads 640 by 480; the row
// pair store is not cleared. cfg_ready is always high.
`include "bayer_row_pair_vertical_upscaler_top_assert.svh"

module bayer_row_pair_vertical_upscaler_top #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480,
    parameter int SHIFT_ROWS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] pixel,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [8:0] out_row,
    output logic [9:0] out_col,
    output logic [7:0] value,
    output logic       last_of_run,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [9:0] cfg_data
);

    logic [9:0]     frame_width_reg;
    logic [8:0]     frame_height_reg;
    brp_pkg::cfg_t  cfg;
    brp_pkg::item_t item;
    logic           take;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= brp_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= brp_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                brp_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                brp_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[8:0];
                default:                   frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // Clamp the frame size to what the store and row range hold.
    always_comb
    begin
        if (frame_width_reg == 10'd0)
        begin
            cfg.width = 10'd1;
        end
        else if ({1'b0, frame_width_reg} > 11'(MAX_WIDTH))
        begin
            cfg.width = 10'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = frame_width_reg;
        end
        cfg.height = ({1'b0, frame_height_reg} > 10'(MAX_HEIGHT))
                     ? 9'(MAX_HEIGHT) : frame_height_reg;
        cfg.shift  = frame_width_reg == brp_pkg::SHIFT_WIDTH;
    end

    brp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .SHIFT_ROWS (SHIFT_ROWS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .pixel    (pixel),
        .take     (take),
        .item     (item)
    );

    brp_emit #(
        .SHIFT_ROWS (SHIFT_ROWS)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .take        (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .value       (value),
        .last_of_run (last_of_run)
    );

    // Results never fall outside the frame in use.
    `BRP_ASSERT_NOW(a_row_in_frame, out_valid, out_row < cfg.height)
    `BRP_ASSERT_NOW(a_col_in_frame, out_valid, out_col < cfg.width)
    // Results of one word stay together and share the column.
    `BRP_ASSERT_NEXT(a_run_holds, out_valid && out_ready && !last_of_run,
        out_valid && (out_col == $past(out_col)))

endmodule

[verif/tb_bayer_row_pair_vertical_upscaler_top.sv]
`timescale 1ns / 100ps

module tb_bayer_row_pair_vertical_upscaler_top;

    localparam int LINE_MAX  = 640;
    localparam int ROWS_MAX  = 480;
    localparam int ROW_SHIFT = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DIR_STEPS = 37;

    // One output word as the result port presents it.
    typedef struct packed {
        logic [8:0] row;
        logic [9:0] col;
        logic [7:0] value;
        logic       last;
    } px_word_t;

    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_WIDTH,
        STEP_HEIGHT
    } step_kind_e;

    // One row of the directed stimulus; want_* holds the single word that
    // the step must produce when typed is set.
    typedef struct packed {
        step_kind_e kind;
        logic [9:0] data;
        logic       typed;
        logic [8:0] want_row;
        logic [9:0] want_col;
        logic [7:0] want_val;
    } dir_step_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } rx_mode_e;

    // The middle rows step through rows of one byte, switch to the shifted
    // width for a few columns, and run into a word whose results all fall
    // past the bottom before the frame wraps.
    localparam dir_step_t DIRECTED [DIR_STEPS] = '{
        '{STEP_PIXEL,  10'h000, 1'b1, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h0FF, 1'b1, 9'd0, 10'd1, 8'hFF},
        '{STEP_PIXEL,  10'h001, 1'b1, 9'd0, 10'd2, 8'h01},
        '{STEP_WIDTH,  10'd0,   1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_HEIGHT, 10'd8,   1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h080, 1'b1, 9'd0, 10'd0, 8'h80},
        '{STEP_PIXEL,  10'h07F, 1'b1, 9'd1, 10'd0, 8'h7F},
        '{STEP_PIXEL,  10'h0FF, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h000, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_HEIGHT, 10'd0,   1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h055, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_HEIGHT, 10'd1,   1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h0AA, 1'b1, 9'd0, 10'd0, 8'hAA},
        '{STEP_WIDTH,  10'd176, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_HEIGHT, 10'd511, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h033, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h0CC, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_HEIGHT, 10'd2,   1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h05A, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_HEIGHT, 10'd12,  1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_WIDTH,  10'd1,   1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h011, 1'b1, 9'd0, 10'd0, 8'h11},
        '{STEP_PIXEL,  10'h0EE, 1'b1, 9'd1, 10'd0, 8'hEE},
        '{STEP_WIDTH,  10'd176, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h0F0, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h00F, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_WIDTH,  10'd1,   1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h077, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h088, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_WIDTH,  10'd176, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h099, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_WIDTH,  10'd1,   1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h044, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h066, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_WIDTH,  10'd1023, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_HEIGHT, 10'd480, 1'b0, 9'd0, 10'd0, 8'h00},
        '{STEP_PIXEL,  10'h0C3, 1'b0, 9'd0, 10'd0, 8'h00}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] pixel;
    logic       out_valid;
    logic       out_ready;
    logic [8:0] out_row;
    logic [9:0] out_col;
    logic [7:0] value;
    logic       last_of_run;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [9:0] cfg_data;

    // Upscaler state as the testbench sees it.
    logic [9:0]  cfg_w = brp_pkg::FRAME_WIDTH_RST;
    logic [8:0]  cfg_h = brp_pkg::FRAME_HEIGHT_RST;
    logic [7:0]  pair_line [2*LINE_MAX];
    int unsigned row_cnt = 0;
    int unsigned col_cnt = 0;

    px_word_t    fresh_px [$];
    px_word_t    expected_px [$];

    int          err_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          valid_up = 1'b0;
    int          hold_token = 0;

    bayer_row_pair_vertical_upscaler_top #(
        .MAX_WIDTH  (LINE_MAX),
        .MAX_HEIGHT (ROWS_MAX),
        .SHIFT_ROWS (ROW_SHIFT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .value       (value),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Place one word at its row, with the in-place and moved copies of the
    // shifted mode, dropping any row past the bottom of the frame.
    task automatic route_px(input int unsigned row, input int unsigned col,
                            input logic [7:0] val, input int unsigned h);
        px_word_t    wd;
        int unsigned moved;
        wd.col   = col[9:0];
        wd.value = val;
        wd.last  = 1'b0;
        moved    = row + ROW_SHIFT;
        if (cfg_w == brp_pkg::SHIFT_WIDTH)
        begin
            if (row < ROW_SHIFT && row < h)
            begin
                wd.row = row[8:0];
                fresh_px.push_back(wd);
            end
            if (moved < h)
            begin
                wd.row = moved[8:0];
                fresh_px.push_back(wd);
            end
        end
        else if (row < h)
        begin
            wd.row = row[8:0];
            fresh_px.push_back(wd);
        end
    endtask

    // Work out the words caused by one accepted input byte and advance the
    // row and column counters.
    task automatic upscale_pixel(input logic [7:0] v);
        int unsigned w;
        int unsigned h;
        int unsigned half;
        int unsigned r;
        int unsigned j;
        int unsigned p;
        int unsigned base;
        int unsigned idx;
        logic [8:0]  pair_sum;
        w = cfg_w;
        h = cfg_h;
        if (w == 0)
            w = 1;
        if (w > LINE_MAX)
            w = LINE_MAX;
        if (h > ROWS_MAX)
            h = ROWS_MAX;
        half = h >> 1;
        r = row_cnt;
        j = col_cnt;
        if (j >= w)
            j = w - 1;
        p    = r & 1;
        base = 2 * r - p;
        idx  = p * LINE_MAX + j;
        fresh_px.delete();
        route_px(base, j, v, h);
        if (r >= 2)
        begin
            pair_sum = {1'b0, pair_line[idx]} + {1'b0, v};
            route_px(base - 2, j, pair_sum[8:1], h);
        end
        if (r + 2 >= half)
            route_px(base + 2, j, v, h);
        pair_line[idx] = v;
        if (fresh_px.size() > 0)
            fresh_px[fresh_px.size() - 1].last = 1'b1;
        if (j + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= half) ? 0 : ((r + 1) & 32'hFF);
        end
        else
        begin
            col_cnt = j + 1;
        end
    endtask

    function automatic logic [7:0] rand_px();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Drop the input valid if it is up.
    task automatic sender_idle();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        burst_left = 0;
    endtask

    // Offer one byte, in bursts separated by random gaps, and record the
    // words it must cause once it is accepted.
    task automatic send_px(input logic [7:0] v, input logic typed, input px_word_t want);
        int gap;
        if (!valid_up)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16) : $urandom_range(1, 2);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 64);
        end
        in_valid <= 1'b1;
        pixel    <= v;
        valid_up = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        upscale_pixel(v);
        if (typed)
            expected_px.push_back(want);
        else
            foreach (fresh_px[k])
                expected_px.push_back(fresh_px[k]);
        burst_left--;
        if (burst_left <= 0)
            sender_idle();
    endtask

    // Stop sending, wait for every expected word, then let the block settle.
    task automatic wait_quiet(input int settle);
        sender_idle();
        while (expected_px.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write one register with the block idle.
    task automatic write_reg(input logic idx, input logic [9:0] data);
        wait_quiet(12);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == brp_pkg::REG_FRAME_WIDTH)
            cfg_w = data;
        else
            cfg_h = data[8:0];
        cfg_valid <= 1'b0;
    endtask

    // Set a frame size and stream random bytes up to a frame boundary.
    task automatic run_phase(input logic [9:0] w, input logic [9:0] h,
                             input int min_items, input bit long_hold);
        int sent;
        write_reg(brp_pkg::REG_FRAME_WIDTH, w);
        write_reg(brp_pkg::REG_FRAME_HEIGHT, h);
        if (long_hold)
            hold_token <= hold_token + 1;
        sent = 0;
        while (sent < min_items || row_cnt != 0 || col_cnt != 0)
        begin
            send_px(rand_px(), 1'b0, '0);
            sent++;
        end
    endtask

    // Result port back-pressure: changing stall patterns plus long hold-offs.
    initial
    begin
        rx_mode_e rx_mode;
        int       mode_left;
        int       hold_seen;
        int       cadence;
        out_ready = 1'b0;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        hold_seen = 0;
        cadence   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            cadence = (cadence + 1) % 3;
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= (cadence != 0);
            endcase
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        px_word_t exp_wd;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_px.size() == 0)
            begin
                $display("%0t: word with no expectation: expected none, %s %0d %0d %0d %0d",
                         $time, "got row, col, value, last", out_row, out_col, value,
                         last_of_run);
                err_count++;
            end
            else
            begin
                exp_wd = expected_px.pop_front();
                if (out_row !== exp_wd.row)
                begin
                    $display("%0t: out_row expected %0d, got %0d", $time, exp_wd.row, out_row);
                    err_count++;
                end
                if (out_col !== exp_wd.col)
                begin
                    $display("%0t: out_col expected %0d, got %0d", $time, exp_wd.col, out_col);
                    err_count++;
                end
                if (value !== exp_wd.value)
                begin
                    $display("%0t: value expected %0d, got %0d", $time, exp_wd.value, value);
                    err_count++;
                end
                if (last_of_run !== exp_wd.last)
                begin
                    $display("%0t: last_of_run expected %0d, got %0d",
                             $time, exp_wd.last, last_of_run);
                    err_count++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random frame phases.
    initial
    begin
        px_word_t want;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        pixel     = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = brp_pkg::REG_FRAME_WIDTH;
        cfg_data  = 10'd0;
        foreach (pair_line[k])
            pair_line[k] = 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset size, extremes, clamping and the shifted mode.
        for (int i = 0; i < DIR_STEPS; i++)
        begin
            want = '{DIRECTED[i].want_row, DIRECTED[i].want_col, DIRECTED[i].want_val, 1'b1};
            case (DIRECTED[i].kind)
                STEP_PIXEL:  send_px(DIRECTED[i].data[7:0], DIRECTED[i].typed, want);
                STEP_WIDTH:  write_reg(brp_pkg::REG_FRAME_WIDTH, DIRECTED[i].data);
                default:     write_reg(brp_pkg::REG_FRAME_HEIGHT, DIRECTED[i].data);
            endcase
        end

        // Whole frames at fixed small sizes, one of them under a long hold.
        run_phase(10'd8, 10'd8, 1, 1'b0);
        run_phase(10'd6, 10'd10, 1, 1'b1);
        run_phase(10'd0, 10'd30, 1, 1'b0);
        run_phase(10'd5, 10'd9, 1, 1'b0);
        run_phase(10'd4, 10'd6, 1, 1'b0);

        // Random small frames, odd heights and tiny heights included.
        repeat (4)
        begin
            run_phase(10'($urandom_range(0, 8)), 10'($urandom_range(0, 16)),
                      $urandom_range(4, 12), 1'b0);
        end

        wait_quiet(24);
        if (err_count == 0 && expected_px.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/brp_pkg.sv
rtl/core/brp_ram.sv
rtl/core/brp_front.sv
rtl/core/brp_emit.sv
rtl/core/bayer_row_pair_vertical_upscaler_top.sv
verif/tb_bayer_row_pair_vertical_upscaler_top.sv
